// ===== rtl/axmix_pkg.sv =====
// Shared types and constants for the axis-to-joint mixer.
// Used by axmix_ctrl, axmix_dp and the top level; no dependencies.
`timescale 1ns / 1ps

package axmix_pkg;

    localparam int JOINTS   = 4;
    localparam int AXES     = 6;
    localparam int JIDX_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int AX_W     = $clog2(AXES);
    localparam int ENTRIES  = AXES * JOINTS;
    localparam int TIDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TICK_W   = 20;
    localparam int TOL_W    = 31;
    localparam int CFG_W    = 31;
    // accumulator holds the exact sum of AXES saturated terms
    localparam int ACC_W    = 32 + $clog2(AXES) + 1;

    localparam logic [TOL_W-1:0]  TOL_RESET     = TOL_W'(655);
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(1000);
    localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};

    // configuration register indexes
    localparam logic CFG_TOL     = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_POS   = 2'd0,
        KIND_VEL   = 2'd1,
        KIND_FLAG  = 2'd2,
        KIND_SPEED = 2'd3
    } word_kind_t;

    typedef enum logic [1:0] {
        MSEL_SPEED = 2'd0,
        MSEL_VEL   = 2'd1,
        MSEL_POS   = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VMUL1,
        ST_VRND1,
        ST_VMUL2,
        ST_VRND2,
        ST_VOUT,
        ST_PMUL,
        ST_PRND,
        ST_PTGT,
        ST_CHK
    } state_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [2:0]            axis_sel;
        logic [1:0]            joint_sel;
        word_kind_t            word_kind;
        logic [31:0]           word;
        logic                  mode;
        logic [AXES-1:0][31:0] axis_value;
    } in_beat_t;

    typedef struct packed {
        logic              capture;
        logic              clr_acc;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              rnd_to_q;
        logic              rnd_to_acc;
        logic              tgt_load;
        logic              out_load;
        logic              last;
        logic [AX_W-1:0]   axis;
        logic [JIDX_W-1:0] joint;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pending;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/axmix_ctrl.sv =====
// Sequencer for the mixer: walks joints and axes through the shared MAC.
// Depends on axmix_pkg; drives axmix_dp through ctrl_cmd_t.
`timescale 1ns / 1ps

module axmix_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            beat_cmd,
    input  logic                  beat_mode,
    input  axmix_pkg::dp_status_t status,
    output axmix_pkg::ctrl_cmd_t  cmd
);
    import axmix_pkg::*;

    state_t            state_reg, state_next;
    logic [AX_W-1:0]   axis_reg, axis_next;
    logic [JIDX_W-1:0] joint_reg, joint_next;
    logic              axis_last, joint_last, accept;

    assign axis_last  = (axis_reg == AX_W'(AXES - 1));
    assign joint_last = (joint_reg == JIDX_W'(JOINTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            joint_reg <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            joint_reg <= joint_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        joint_next     = joint_reg;
        s_ready        = (state_reg == ST_IDLE);
        accept         = s_valid && s_ready;
        cmd            = '0;
        cmd.mul_sel    = MSEL_SPEED;
        cmd.axis       = axis_reg;
        cmd.joint      = joint_reg;
        cmd.last       = joint_last;
        cmd.capture    = accept;

        unique case (state_reg)
            ST_IDLE: begin
                axis_next  = '0;
                joint_next = '0;
                if (accept && beat_cmd == CMD_TICK) begin
                    cmd.clr_acc = 1'b1;
                    if (!beat_mode)
                        state_next = ST_VMUL1;
                    else if (status.pending)
                        state_next = ST_PMUL;
                    else
                        state_next = ST_CHK;
                end
            end
            ST_VMUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_SPEED;
                state_next  = ST_VRND1;
            end
            ST_VRND1: begin
                cmd.rnd_to_q = 1'b1;
                state_next   = ST_VMUL2;
            end
            ST_VMUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_VEL;
                state_next  = ST_VRND2;
            end
            ST_VRND2: begin
                cmd.rnd_to_acc = 1'b1;
                if (axis_last) begin
                    state_next = ST_VOUT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_VMUL1;
                end
            end
            ST_VOUT: begin
                // hold until the output register can take the beat
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.clr_acc  = 1'b1;
                    axis_next    = '0;
                    if (joint_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        joint_next = joint_reg + 1'b1;
                        state_next = ST_VMUL1;
                    end
                end
            end
            ST_PMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_POS;
                state_next  = ST_PRND;
            end
            ST_PRND: begin
                cmd.rnd_to_acc = 1'b1;
                if (axis_last) begin
                    state_next = ST_PTGT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_PMUL;
                end
            end
            ST_PTGT: begin
                cmd.tgt_load = 1'b1;
                cmd.clr_acc  = 1'b1;
                axis_next    = '0;
                if (joint_last) begin
                    joint_next = '0;
                    state_next = ST_CHK;
                end else begin
                    joint_next = joint_reg + 1'b1;
                    state_next = ST_PMUL;
                end
            end
            ST_CHK: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (joint_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        joint_next = joint_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/axmix_dp.sv =====
// Datapath for the mixer: coefficient tables, joint state, shared MAC,
// arrival check and output register. Depends on axmix_pkg.
`timescale 1ns / 1ps

module axmix_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  axmix_pkg::in_beat_t      beat,
    input  axmix_pkg::ctrl_cmd_t     cmd,
    output axmix_pkg::dp_status_t    status,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [axmix_pkg::CFG_W-1:0] cfg_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_joint_index,
    output logic signed [31:0]       m_joint_command,
    output logic                     m_out_mode,
    output logic                     m_joint_arrived,
    output logic                     m_last_joint
);
    import axmix_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // tables and joint state
    logic signed [31:0] pos_coef_reg [ENTRIES];
    logic signed [31:0] vel_coef_reg [ENTRIES];
    logic               flag_reg     [ENTRIES];
    logic signed [31:0] speed_reg    [AXES];
    logic signed [31:0] jpos_reg     [JOINTS];
    logic signed [31:0] target_reg   [JOINTS];
    logic signed [31:0] val_reg      [AXES];

    logic               mode_reg;
    logic               pending_reg;
    logic               all_arr_reg;
    logic [TICK_W-1:0]  ticks_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [TICK_W-1:0]  timeout_reg;

    logic signed [63:0]    prod_reg;
    logic signed [31:0]    q_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic               out_valid_reg;
    logic [1:0]         out_index_reg;
    logic signed [31:0] out_cmd_reg;
    logic               out_mode_reg;
    logic               out_arr_reg;
    logic               out_last_reg;

    // beat decode
    logic              is_load, is_report, is_tick;
    logic              load_axis_ok, load_joint_ok;
    logic [TIDX_W-1:0] load_idx;
    logic [AX_W-1:0]   load_axis;
    logic [JIDX_W-1:0] load_joint;

    assign is_load       = cmd.capture && (beat.cmd == CMD_LOAD);
    assign is_report     = cmd.capture && (beat.cmd == CMD_REPORT);
    assign is_tick       = cmd.capture && (beat.cmd == CMD_TICK);
    assign load_axis_ok  = (int'(beat.axis_sel) < AXES);
    assign load_joint_ok = (int'(beat.joint_sel) < JOINTS);
    assign load_axis     = AX_W'(beat.axis_sel);
    assign load_joint    = JIDX_W'(beat.joint_sel);
    assign load_idx      = TIDX_W'(int'(beat.axis_sel) * JOINTS + int'(beat.joint_sel));

    // MAC operands
    logic [TIDX_W-1:0]  idx;
    logic signed [31:0] val_sel, dir_v, op_a, op_b;
    logic signed [63:0] prod_next, rnd_sum, rnd_shift;
    logic signed [31:0] q_sat;

    assign idx     = TIDX_W'(int'(cmd.axis) * JOINTS + int'(cmd.joint));
    assign val_sel = val_reg[cmd.axis];

    always_comb begin
        // fixed-direction entries take the magnitude, most negative saturates
        if (flag_reg[idx] && val_sel[31])
            dir_v = (val_sel == 32'sh80000000) ? 32'sh7FFFFFFF : -val_sel;
        else
            dir_v = val_sel;
        unique case (cmd.mul_sel)
            MSEL_SPEED: begin
                op_a = dir_v;
                op_b = speed_reg[cmd.axis];
            end
            MSEL_VEL: begin
                op_a = q_reg;
                op_b = vel_coef_reg[idx];
            end
            MSEL_POS: begin
                op_a = dir_v;
                op_b = pos_coef_reg[idx];
            end
            default: begin
                op_a = dir_v;
                op_b = speed_reg[cmd.axis];
            end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign rnd_sum   = prod_reg + 64'sd32768;
    assign rnd_shift = rnd_sum >>> 16;
    assign q_sat     = sat32(rnd_shift);

    // joint result paths
    logic signed [31:0] acc_sat, tgt_cur, pos_cur, tgt_next;
    logic signed [32:0] tgt_sum;
    logic signed [33:0] diff, tol_s;
    logic               arrived;

    assign acc_sat  = sat32(64'(acc_reg));
    assign pos_cur  = jpos_reg[cmd.joint];
    assign tgt_cur  = target_reg[cmd.joint];
    assign tgt_sum  = 33'(acc_sat) + 33'(pos_cur);
    assign tgt_next = sat32(64'(tgt_sum));
    assign diff     = 34'(tgt_cur) - 34'(pos_cur);
    assign tol_s    = $signed({3'b000, tol_reg});
    assign arrived  = (diff <= tol_s) && (diff >= -tol_s);

    assign status.pending  = pending_reg;
    assign status.out_free = !out_valid_reg || m_ready;

    // payload stores, no reset
    always_ff @(posedge aclk) begin
        if (is_load && load_axis_ok) begin
            if (beat.word_kind == KIND_SPEED) begin
                speed_reg[load_axis] <= beat.word;
            end else if (load_joint_ok) begin
                unique case (beat.word_kind)
                    KIND_POS:  pos_coef_reg[load_idx] <= beat.word;
                    KIND_VEL:  vel_coef_reg[load_idx] <= beat.word;
                    KIND_FLAG: flag_reg[load_idx]     <= (beat.word != '0);
                    default: ;
                endcase
            end
        end
        if (is_report && load_joint_ok)
            jpos_reg[load_joint] <= beat.word;
        if (is_tick) begin
            for (int a = 0; a < AXES; a++)
                val_reg[a] <= beat.axis_value[a];
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.rnd_to_q)
            q_reg <= q_sat;
        if (cmd.clr_acc)
            acc_reg <= '0;
        else if (cmd.rnd_to_acc)
            acc_reg <= acc_reg + ACC_W'(q_sat);
        if (cmd.out_load) begin
            out_index_reg <= 2'(cmd.joint);
            out_mode_reg  <= mode_reg;
            out_last_reg  <= cmd.last;
            if (!mode_reg) begin
                out_cmd_reg <= acc_sat;
                out_arr_reg <= 1'b0;
            end else begin
                out_cmd_reg <= arrived ? pos_cur : tgt_cur;
                out_arr_reg <= arrived;
            end
        end
    end

    // control state and targets
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            pending_reg   <= 1'b1;
            all_arr_reg   <= 1'b1;
            ticks_reg     <= '0;
            tol_reg       <= TOL_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < JOINTS; j++)
                target_reg[j] <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TOL:     tol_reg     <= cfg_data[TOL_W-1:0];
                    CFG_TIMEOUT: timeout_reg <= cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (is_tick) begin
                mode_reg    <= beat.mode;
                all_arr_reg <= 1'b1;
                if (!beat.mode) begin
                    pending_reg <= 1'b1;
                end else if (pending_reg) begin
                    ticks_reg   <= '0;
                    pending_reg <= 1'b0;
                end else if (ticks_reg != TICK_MAX) begin
                    ticks_reg <= ticks_reg + 1'b1;
                end
            end
            if (cmd.tgt_load)
                target_reg[cmd.joint] <= tgt_next;
            if (cmd.out_load && mode_reg) begin
                // snap to position once within the band
                if (arrived)
                    target_reg[cmd.joint] <= pos_cur;
                all_arr_reg <= all_arr_reg && arrived;
                if (cmd.last && ((all_arr_reg && arrived) || ticks_reg >= timeout_reg))
                    pending_reg <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_joint_index   = out_index_reg;
    assign m_joint_command = out_cmd_reg;
    assign m_out_mode      = out_mode_reg;
    assign m_joint_arrived = out_arr_reg;
    assign m_last_joint    = out_last_reg;

endmodule

// ===== rtl/axis_to_joint_mixer_stepper_unit.sv =====
// Axis-to-joint mixer top level: table loads, position reports, control ticks.
// Load and report beats give no result.
// Velocity tick: per joint, each axis goes through the shared multiplier and its rounding
// stage for speed, then for the velocity coefficient; ST_VOUT waits for a free output.
// Position tick, latch pending: PMUL/PRND per axis, PTGT per joint, then ST_CHK; else ST_CHK.
// Reset (aresetn, synchronous): targets zero, velocity mode, latch pending, tables undefined.
`timescale 1ns / 1ps

module axis_to_joint_mixer_stepper_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [axmix_pkg::CFG_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [2:0]                  s_axis_sel,
    input  logic [1:0]                  s_joint_sel,
    input  logic [1:0]                  s_word_kind,
    input  logic signed [31:0]          s_word,
    input  logic                        s_mode,
    input  logic signed [31:0]          s_axis_value_0,
    input  logic signed [31:0]          s_axis_value_1,
    input  logic signed [31:0]          s_axis_value_2,
    input  logic signed [31:0]          s_axis_value_3,
    input  logic signed [31:0]          s_axis_value_4,
    input  logic signed [31:0]          s_axis_value_5,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_joint_index,
    output logic signed [31:0]          m_joint_command,
    output logic                        m_out_mode,
    output logic                        m_joint_arrived,
    output logic                        m_last_joint
);
    import axmix_pkg::*;

    in_beat_t   beat;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    always_comb begin
        beat.cmd           = s_cmd;
        beat.axis_sel      = s_axis_sel;
        beat.joint_sel     = s_joint_sel;
        beat.word_kind     = word_kind_t'(s_word_kind);
        beat.word          = s_word;
        beat.mode          = s_mode;
        beat.axis_value[0] = s_axis_value_0;
        beat.axis_value[1] = s_axis_value_1;
        beat.axis_value[2] = s_axis_value_2;
        beat.axis_value[3] = s_axis_value_3;
        beat.axis_value[4] = s_axis_value_4;
        beat.axis_value[5] = s_axis_value_5;
    end

    axmix_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .beat_cmd  (s_cmd),
        .beat_mode (s_mode),
        .status    (status),
        .cmd       (cmd)
    );

    axmix_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .beat            (beat),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_joint_index   (m_joint_index),
        .m_joint_command (m_joint_command),
        .m_out_mode      (m_out_mode),
        .m_joint_arrived (m_joint_arrived),
        .m_last_joint    (m_last_joint)
    );

endmodule
